// File: hdl/segregated_fixed_block_allocator_top_defines.svh
// Assertion macros shared by the allocator's checker.
// Each macro samples on clk and is disabled while rst is high.
`ifndef SEGREGATED_FIXED_BLOCK_ALLOCATOR_TOP_DEFINES_SVH
`define SEGREGATED_FIXED_BLOCK_ALLOCATOR_TOP_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SFBA_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SFBA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: hdl/sfba_pkg.sv
// Shared types and codes for the segregated fixed-block allocator.
// No dependencies; used by every module of the block except the link memory.
`default_nettype none

package sfba_pkg;

  localparam int ADDR_W = 32;
  localparam int REQ_W  = 16;
  localparam int HDR_W  = 4;

  // Operation codes carried by the opcode field.
  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  // Result status codes.
  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_EMPTY     = 2'd1;
  localparam logic [1:0] STATUS_TOO_LARGE = 2'd2;
  localparam logic [1:0] STATUS_BAD_FREE  = 2'd3;

  // Pool classes.
  localparam logic [1:0] CLS_SMALL  = 2'd0;
  localparam logic [1:0] CLS_MEDIUM = 2'd1;
  localparam logic [1:0] CLS_LARGE  = 2'd2;

  // Configuration register indexes (paddr bit 2).
  localparam logic REG_REGION_BASE  = 1'b0;
  localparam logic REG_HEADER_BYTES = 1'b1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic decode;
    logic commit;
  } cmd_t;

endpackage

`default_nettype wire

// File: hdl/sfba_link_mem.sv
// Free-list link memory: one successor entry per block, with registered read.
// Per-entry written bits make unwritten entries read as their reset chain.
`default_nettype none

module sfba_link_mem #(
  parameter int SMALL_COUNT  = 8,
  parameter int MEDIUM_COUNT = 8,
  parameter int LARGE_COUNT  = 4,
  localparam int TOTAL = SMALL_COUNT + MEDIUM_COUNT + LARGE_COUNT,
  localparam int IDX_W = $clog2(TOTAL)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             rd_en,
  input  logic [IDX_W-1:0] rd_addr,
  output logic [IDX_W-1:0] rd_link,
  output logic             rd_valid,
  input  logic             wr_en,
  input  logic [IDX_W-1:0] wr_addr,
  input  logic [IDX_W-1:0] wr_link,
  input  logic             wr_valid
);

  localparam int ENT_W = IDX_W + 1;

  logic [ENT_W-1:0] mem [TOTAL];
  logic [TOTAL-1:0] written;
  logic [ENT_W-1:0] rd_q;
  logic             rd_written;
  logic [IDX_W-1:0] rd_addr_q;
  logic             last_of_pool;
  logic [IDX_W-1:0] reset_link;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= {wr_valid, wr_link};
    end
    if (rd_en) begin
      rd_q      <= mem[rd_addr];
      rd_addr_q <= rd_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      written    <= '0;
      rd_written <= 1'b0;
    end else begin
      if (wr_en) begin
        written[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_written <= written[rd_addr];
      end
    end
  end

  // At reset every block points at its neighbour, the last of each pool at none.
  assign last_of_pool = (rd_addr_q == IDX_W'(SMALL_COUNT - 1)) ||
                        (rd_addr_q == IDX_W'(SMALL_COUNT + MEDIUM_COUNT - 1)) ||
                        (rd_addr_q == IDX_W'(TOTAL - 1));
  assign reset_link   = last_of_pool ? '0 : rd_addr_q + IDX_W'(1);

  assign rd_link  = rd_written ? rd_q[IDX_W-1:0] : reset_link;
  assign rd_valid = rd_written ? rd_q[IDX_W]     : !last_of_pool;

endmodule

`default_nettype wire

// File: hdl/sfba_ctrl.sv
// Controller state machine for the allocator: sequences load, decode, commit.
// Depends on sfba_pkg for the command struct.
`default_nettype none

module sfba_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  output logic          out_valid,
  input  logic          out_stall,
  output sfba_pkg::cmd_t cmd
);

  import sfba_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DECODE,
    S_COMMIT
  } state_t;

  state_t state;
  logic   commit_go;
  logic   accept;

  // Commit only when the output register is free or is being emptied.
  assign commit_go = (state == S_COMMIT) && (!out_valid || !out_stall);
  assign in_stall  = !((state == S_IDLE) || commit_go);
  assign accept    = in_valid && !in_stall;

  assign cmd.load   = accept;
  assign cmd.decode = (state == S_DECODE);
  assign cmd.commit = commit_go;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (commit_go) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            state <= S_DECODE;
          end
        end
        S_DECODE: begin
          state <= S_COMMIT;
        end
        S_COMMIT: begin
          if (commit_go) begin
            state <= accept ? S_DECODE : S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// File: hdl/sfba_datapath.sv
// Allocator datapath: input and decode registers, pool heads, in-use marks,
// address arithmetic and the result register. Uses sfba_pkg and sfba_link_mem.
`default_nettype none

module sfba_datapath #(
  parameter int SMALL_BYTES  = 16,
  parameter int SMALL_COUNT  = 8,
  parameter int MEDIUM_BYTES = 32,
  parameter int MEDIUM_COUNT = 8,
  parameter int LARGE_BYTES  = 64,
  parameter int LARGE_COUNT  = 4,
  localparam int TOTAL = SMALL_COUNT + MEDIUM_COUNT + LARGE_COUNT,
  localparam int IDX_W = $clog2(TOTAL)
) (
  input  logic                          clk,
  input  logic                          rst,
  input  sfba_pkg::cmd_t                cmd,
  input  logic                          opcode,
  input  logic [sfba_pkg::REQ_W-1:0]    request_bytes,
  input  logic [sfba_pkg::ADDR_W-1:0]   user_address,
  input  logic [sfba_pkg::ADDR_W-1:0]   region_base,
  input  logic [sfba_pkg::HDR_W-1:0]    header_bytes,
  output logic [sfba_pkg::ADDR_W-1:0]   granted_address,
  output logic [1:0]                    status,
  output logic [1:0]                    pool_class
);

  import sfba_pkg::*;

  localparam int PB    [3] = '{SMALL_BYTES, MEDIUM_BYTES, LARGE_BYTES};
  localparam int FIRST [3] = '{0, SMALL_COUNT, SMALL_COUNT + MEDIUM_COUNT};
  localparam int START [3] = '{0, SMALL_BYTES * SMALL_COUNT,
                               SMALL_BYTES * SMALL_COUNT + MEDIUM_BYTES * MEDIUM_COUNT};
  localparam int SPAN  [3] = '{SMALL_BYTES * SMALL_COUNT, MEDIUM_BYTES * MEDIUM_COUNT,
                               LARGE_BYTES * LARGE_COUNT};

  // Input registers.
  logic              in_op;
  logic [REQ_W-1:0]  in_req;
  logic [ADDR_W-1:0] in_uaddr;

  // Pool state.
  logic [IDX_W-1:0] head [3];
  logic [2:0]       head_valid;
  logic [TOTAL-1:0] in_use;

  // Decode results.
  logic              d_op;
  logic              d_ok;
  logic [1:0]        d_cls;
  logic [1:0]        d_status;
  logic [IDX_W-1:0]  d_blk;
  logic [ADDR_W-1:0] d_addr;
  logic [IDX_W-1:0]  d_head;
  logic              d_hv;

  // Per-pool decode terms.
  logic [2:0]        fit;
  logic [2:0]        inrange;
  logic [2:0]        aligned;
  logic [ADDR_W-1:0] pool_addr [3];
  logic [ADDR_W-1:0] rel [3];
  logic [IDX_W-1:0]  fblk [3];
  logic [ADDR_W-1:0] off;

  // Selected terms.
  logic              a_found;
  logic [1:0]        a_cls;
  logic [IDX_W-1:0]  a_head;
  logic              a_hv;
  logic [ADDR_W-1:0] a_part;
  logic              f_found;
  logic [1:0]        f_cls;
  logic [IDX_W-1:0]  f_head;
  logic              f_hv;
  logic [IDX_W-1:0]  f_blk;
  logic              f_aligned;

  logic              n_ok;
  logic [1:0]        n_cls;
  logic [1:0]        n_status;
  logic [IDX_W-1:0]  n_blk;
  logic [ADDR_W-1:0] n_addr;

  // Link memory port.
  logic [IDX_W-1:0] rd_link;
  logic             rd_valid;
  logic             wr_en;
  logic [IDX_W-1:0] wr_link;
  logic             wr_valid;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      in_op    <= opcode;
      in_req   <= request_bytes;
      in_uaddr <= user_address;
    end
  end

  assign off = in_uaddr - ADDR_W'(header_bytes) - region_base;

  for (genvar c = 0; c < 3; c++) begin : g_pool
    localparam int                LG     = $clog2(PB[c]);
    localparam logic [16:0]       PBW    = 17'(PB[c]);
    localparam logic [ADDR_W-1:0] ADJ    = ADDR_W'(START[c] - FIRST[c] * PB[c]);
    localparam logic [ADDR_W-1:0] STARTW = ADDR_W'(START[c]);
    localparam logic [ADDR_W-1:0] SPANW  = ADDR_W'(SPAN[c]);
    localparam logic [ADDR_W-1:0] MASKW  = ADDR_W'(PB[c] - 1);
    localparam logic [IDX_W-1:0]  FIRSTW = IDX_W'(FIRST[c]);

    assign fit[c] = (PBW >= 17'(header_bytes)) &&
                    (17'(in_req) <= PBW - 17'(header_bytes));
    // Block start relative to region_base: offset of the pool plus index times size.
    assign pool_addr[c] = (ADDR_W'(head[c]) << LG) + ADJ;
    assign rel[c]       = off - STARTW;
    assign inrange[c]   = (off >= STARTW) && (rel[c] < SPANW);
    assign aligned[c]   = (rel[c] & MASKW) == '0;
    assign fblk[c]      = FIRSTW + IDX_W'(rel[c] >> LG);
  end

  always_comb begin
    a_found = 1'b1;
    if (fit[0]) begin
      a_cls = CLS_SMALL;
    end else if (fit[1]) begin
      a_cls = CLS_MEDIUM;
    end else if (fit[2]) begin
      a_cls = CLS_LARGE;
    end else begin
      a_cls   = CLS_SMALL;
      a_found = 1'b0;
    end

    f_found = 1'b1;
    if (inrange[0]) begin
      f_cls = CLS_SMALL;
    end else if (inrange[1]) begin
      f_cls = CLS_MEDIUM;
    end else if (inrange[2]) begin
      f_cls = CLS_LARGE;
    end else begin
      f_cls   = CLS_SMALL;
      f_found = 1'b0;
    end

    case (a_cls)
      CLS_MEDIUM: begin
        a_head = head[1]; a_hv = head_valid[1]; a_part = pool_addr[1];
      end
      CLS_LARGE: begin
        a_head = head[2]; a_hv = head_valid[2]; a_part = pool_addr[2];
      end
      default: begin
        a_head = head[0]; a_hv = head_valid[0]; a_part = pool_addr[0];
      end
    endcase

    case (f_cls)
      CLS_MEDIUM: begin
        f_head = head[1]; f_hv = head_valid[1]; f_blk = fblk[1]; f_aligned = aligned[1];
      end
      CLS_LARGE: begin
        f_head = head[2]; f_hv = head_valid[2]; f_blk = fblk[2]; f_aligned = aligned[2];
      end
      default: begin
        f_head = head[0]; f_hv = head_valid[0]; f_blk = fblk[0]; f_aligned = aligned[0];
      end
    endcase

    n_addr = '0;
    if (in_op == OP_ALLOC) begin
      n_blk = a_head;
      n_cls = a_cls;
      n_ok  = 1'b0;
      if (!a_found) begin
        n_status = STATUS_TOO_LARGE;
      end else if (!a_hv) begin
        n_status = STATUS_EMPTY;
      end else begin
        n_status = STATUS_OK;
        n_ok     = 1'b1;
        n_addr   = region_base + a_part + ADDR_W'(header_bytes);
      end
    end else begin
      n_blk    = f_blk;
      n_ok     = f_found && f_aligned && in_use[f_blk];
      n_status = n_ok ? STATUS_OK : STATUS_BAD_FREE;
      n_cls    = n_ok ? f_cls : CLS_SMALL;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.decode) begin
      d_op     <= in_op;
      d_ok     <= n_ok;
      d_cls    <= n_cls;
      d_status <= n_status;
      d_blk    <= n_blk;
      d_addr   <= n_addr;
      d_head   <= f_head;
      d_hv     <= f_hv;
    end
  end

  // Commit: pop the head on allocate, push the block on free.
  assign wr_en    = cmd.commit && d_ok;
  assign wr_link  = (d_op == OP_ALLOC) ? '0 : d_head;
  assign wr_valid = (d_op == OP_ALLOC) ? 1'b0 : d_hv;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int c = 0; c < 3; c++) begin
        head[c] <= IDX_W'(FIRST[c]);
      end
      head_valid <= '1;
      in_use     <= '0;
    end else if (wr_en) begin
      case (d_cls)
        CLS_MEDIUM: begin
          head[1]       <= (d_op == OP_ALLOC) ? rd_link : d_blk;
          head_valid[1] <= (d_op == OP_ALLOC) ? rd_valid : 1'b1;
        end
        CLS_LARGE: begin
          head[2]       <= (d_op == OP_ALLOC) ? rd_link : d_blk;
          head_valid[2] <= (d_op == OP_ALLOC) ? rd_valid : 1'b1;
        end
        default: begin
          head[0]       <= (d_op == OP_ALLOC) ? rd_link : d_blk;
          head_valid[0] <= (d_op == OP_ALLOC) ? rd_valid : 1'b1;
        end
      endcase
      in_use[d_blk] <= (d_op == OP_ALLOC);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      granted_address <= d_addr;
      status          <= d_status;
      pool_class      <= d_cls;
    end
  end

  sfba_link_mem #(
    .SMALL_COUNT  (SMALL_COUNT),
    .MEDIUM_COUNT (MEDIUM_COUNT),
    .LARGE_COUNT  (LARGE_COUNT)
  ) u_link_mem (
    .clk      (clk),
    .rst      (rst),
    .rd_en    (cmd.decode),
    .rd_addr  (a_head),
    .rd_link  (rd_link),
    .rd_valid (rd_valid),
    .wr_en    (wr_en),
    .wr_addr  (d_blk),
    .wr_link  (wr_link),
    .wr_valid (wr_valid)
  );

endmodule

`default_nettype wire

// File: hdl/segregated_fixed_block_allocator_top.sv
// Segregated fixed-block allocator top level: configuration registers, controller, datapath.
// A result is presented once its request has passed the input, decode and result registers.
// A new request beat is taken while idle or in the previous request's commit cycle, as the
// registered link memory read must precede each head update. Output stalls delay the commit.
// Reset (rst, synchronous): every pool's free list holds all its blocks, nothing is in use.
`default_nettype none

module segregated_fixed_block_allocator_top #(
  parameter int SMALL_BYTES  = 16,
  parameter int SMALL_COUNT  = 8,
  parameter int MEDIUM_BYTES = 32,
  parameter int MEDIUM_COUNT = 8,
  parameter int LARGE_BYTES  = 64,
  parameter int LARGE_COUNT  = 4
) (
  input  logic                        clk,
  input  logic                        rst,
  // Request channel.
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        opcode,
  input  logic [sfba_pkg::REQ_W-1:0]  request_bytes,
  input  logic [sfba_pkg::ADDR_W-1:0] user_address,
  // Result channel.
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [sfba_pkg::ADDR_W-1:0] granted_address,
  output logic [1:0]                  status,
  output logic [1:0]                  pool_class,
  // Configuration port.
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [2:0]                  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);

  import sfba_pkg::*;

  // The link memory holds one entry per block. Rather than sweeping it after
  // reset, each entry has a written bit; an entry never written reads as its
  // reset chain, so the block accepts requests as soon as reset is released.

  logic [ADDR_W-1:0] region_base;
  logic [HDR_W-1:0]  header_bytes;
  logic              cfg_write;
  cmd_t              cmd;

  // The two registers sit at byte addresses 0 and 4; bit 2 of paddr picks one.
  // The port never waits, so pready is tied high.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      region_base  <= '0;
      header_bytes <= HDR_W'(8);
    end else if (cfg_write) begin
      case (paddr[2])
        REG_REGION_BASE: begin
          region_base <= pwdata;
        end
        REG_HEADER_BYTES: begin
          header_bytes <= pwdata[HDR_W-1:0];
        end
        default: begin
          region_base <= region_base;
        end
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_HEADER_BYTES: prdata = 32'(header_bytes);
      default:          prdata = region_base;
    endcase
  end

  // The controller steps each request through a decode cycle, in which the
  // pool is chosen and the link memory is read at that pool's head, and a
  // commit cycle, in which the free list and in-use marks are updated and the
  // result is loaded. A new request beat is taken in the commit cycle, so the next
  // request is registered while the previous one commits. The result register parts the
  // two channels: the commit simply waits while a previous result is stalled.
  sfba_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  // The datapath holds the three free-list heads, the in-use marks, the link
  // memory and the address arithmetic. Pool sizes are powers of two, so block
  // index and alignment come from shifts and masks of the offset.
  sfba_datapath #(
    .SMALL_BYTES  (SMALL_BYTES),
    .SMALL_COUNT  (SMALL_COUNT),
    .MEDIUM_BYTES (MEDIUM_BYTES),
    .MEDIUM_COUNT (MEDIUM_COUNT),
    .LARGE_BYTES  (LARGE_BYTES),
    .LARGE_COUNT  (LARGE_COUNT)
  ) u_datapath (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .opcode          (opcode),
    .request_bytes   (request_bytes),
    .user_address    (user_address),
    .region_base     (region_base),
    .header_bytes    (header_bytes),
    .granted_address (granted_address),
    .status          (status),
    .pool_class      (pool_class)
  );

endmodule

`default_nettype wire

// File: hdl/sfba_checker.sv
// Port-level checker for the allocator, bound to the top level.
// Depends on sfba_pkg and the assertion macro header.
`default_nettype none
`include "segregated_fixed_block_allocator_top_defines.svh"

module sfba_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [31:0] granted_address,
  input wire logic [1:0]  status,
  input wire logic [1:0]  pool_class
);

  import sfba_pkg::*;

  // A stalled result beat stays presented.
  `SFBA_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid, "result beat dropped while stalled")
  // Failed requests never hand out an address.
  `SFBA_ASSERT_SAME(a_err_zero, out_valid && (status != STATUS_OK), granted_address == '0, "address on error")
  // Rejected frees and oversize requests report the small class.
  `SFBA_ASSERT_SAME(a_err_cls, out_valid && (status == STATUS_BAD_FREE || status == STATUS_TOO_LARGE), pool_class == CLS_SMALL, "class on error")
  // Only three pools exist.
  `SFBA_ASSERT_SAME(a_cls_range, out_valid, pool_class != 2'd3, "pool class out of range")

endmodule

bind segregated_fixed_block_allocator_top sfba_checker u_sfba_checker (
  .clk             (clk),
  .rst             (rst),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .granted_address (granted_address),
  .status          (status),
  .pool_class      (pool_class)
);

`default_nettype wire

// File: test/segregated_fixed_block_allocator_checker.sv
// Scoreboard for the segregated fixed-block allocator. It watches the configuration
// port and both beat channels, predicts every result and compares it field by field.
// Depends on sfba_pkg for the operation, status, pool and register codes.
`timescale 1ns / 1ps

module segregated_fixed_block_allocator_checker #(
  parameter int SMALL_BYTES  = 16,
  parameter int SMALL_COUNT  = 8,
  parameter int MEDIUM_BYTES = 32,
  parameter int MEDIUM_COUNT = 8,
  parameter int LARGE_BYTES  = 64,
  parameter int LARGE_COUNT  = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic        opcode,
  input  logic [15:0] request_bytes,
  input  logic [31:0] user_address,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [31:0] granted_address,
  input  logic [1:0]  status,
  input  logic [1:0]  pool_class,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int          mismatches,
  output int          outstanding
);
  import sfba_pkg::*;

  localparam int BLOCKS = SMALL_COUNT + MEDIUM_COUNT + LARGE_COUNT;

  typedef struct packed {
    logic [31:0] addr;
    logic [1:0]  status;
    logic [1:0]  cls;
  } grant_t;

  int unsigned blk_bytes[3]  = '{SMALL_BYTES, MEDIUM_BYTES, LARGE_BYTES};
  int unsigned blk_count[3]  = '{SMALL_COUNT, MEDIUM_COUNT, LARGE_COUNT};
  int unsigned blk_first[3]  = '{0, SMALL_COUNT, SMALL_COUNT + MEDIUM_COUNT};
  int unsigned blk_offset[3] = '{0, SMALL_BYTES * SMALL_COUNT,
                                 SMALL_BYTES * SMALL_COUNT + MEDIUM_BYTES * MEDIUM_COUNT};
  logic [1:0]  cls_code[3]   = '{CLS_SMALL, CLS_MEDIUM, CLS_LARGE};

  logic [31:0] base_q;
  logic [3:0]  hdr_q;
  int unsigned link_to[BLOCKS];
  bit          link_ok[BLOCKS];
  bit          taken[BLOCKS];
  int unsigned head[3];
  bit          head_ok[3];
  grant_t      awaited_grants[$];

  // Every pool's free list holds all of its blocks in address order.
  function automatic void reset_pools();
    int unsigned b;
    base_q = '0;
    hdr_q  = 4'd8;
    for (int c = 0; c < 3; c++) begin
      for (int unsigned i = 0; i < blk_count[c]; i++) begin
        b          = blk_first[c] + i;
        taken[b]   = 1'b0;
        link_ok[b] = (i + 1 < blk_count[c]);
        link_to[b] = (i + 1 < blk_count[c]) ? b + 1 : 0;
      end
      head[c]    = blk_first[c];
      head_ok[c] = 1'b1;
    end
  endfunction

  function automatic grant_t serve_request(logic op, logic [15:0] req, logic [31:0] uaddr);
    grant_t      r;
    int          pick;
    int unsigned b;
    logic [31:0] offs;
    logic [31:0] rel;
    bit          found;
    r     = '{addr: '0, status: STATUS_TOO_LARGE, cls: CLS_SMALL};
    pick  = 3;
    found = 1'b0;
    if (op == OP_ALLOC) begin
      for (int c = 0; c < 3; c++) begin
        if (pick == 3 && blk_bytes[c] >= hdr_q && req <= blk_bytes[c] - hdr_q) pick = c;
      end
      if (pick < 3) begin
        r.cls = cls_code[pick];
        if (!head_ok[pick]) begin
          r.status = STATUS_EMPTY;
        end else begin
          b             = head[pick];
          head_ok[pick] = link_ok[b];
          head[pick]    = link_to[b];
          link_ok[b]    = 1'b0;
          link_to[b]    = 0;
          taken[b]      = 1'b1;
          r.addr   = base_q + blk_offset[pick] + (b - blk_first[pick]) * blk_bytes[pick]
                     + 32'(hdr_q);
          r.status = STATUS_OK;
        end
      end
    end else begin
      r.status = STATUS_BAD_FREE;
      offs = uaddr - 32'(hdr_q) - base_q;
      for (int c = 0; c < 3; c++) begin
        if (!found && offs >= blk_offset[c] &&
            offs - blk_offset[c] < blk_bytes[c] * blk_count[c]) begin
          found = 1'b1;
          rel   = offs - blk_offset[c];
          if (rel % blk_bytes[c] == 0) begin
            b = blk_first[c] + rel / blk_bytes[c];
            if (taken[b]) begin
              link_to[b] = head[c];
              link_ok[b] = head_ok[c];
              head[c]    = b;
              head_ok[c] = 1'b1;
              taken[b]   = 1'b0;
              r.status   = STATUS_OK;
              r.cls      = cls_code[c];
            end
          end
        end
      end
    end
    return r;
  endfunction

  function automatic void flag(string what, grant_t want, grant_t seen);
    if (mismatches < 10)
      $display("%0t: %s: expected addr %h status %0d class %0d, got addr %h status %0d class %0d",
               $time, what, want.addr, want.status, want.cls,
               seen.addr, seen.status, seen.cls);
    mismatches++;
  endfunction

  initial begin
    mismatches  = 0;
    outstanding = 0;
    reset_pools();
  end

  always @(posedge clk) begin : snoop
    grant_t seen;
    grant_t want;
    if (rst) begin
      reset_pools();
      awaited_grants.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[2])
          REG_REGION_BASE:  base_q = pwdata;
          REG_HEADER_BYTES: hdr_q  = pwdata[3:0];
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        seen = '{addr: granted_address, status: status, cls: pool_class};
        if (awaited_grants.size() == 0) begin
          flag("result beat with no request outstanding", '0, seen);
        end else begin
          want = awaited_grants.pop_front();
          if (seen.addr !== want.addr || seen.status !== want.status ||
              seen.cls !== want.cls)
            flag("result mismatch", want, seen);
        end
      end
      if (in_valid && !in_stall)
        awaited_grants.push_back(serve_request(opcode, request_bytes, user_address));
    end
    outstanding = awaited_grants.size();
  end

endmodule

// File: test/segregated_fixed_block_allocator_top_test.sv
// Regression bench for segregated_fixed_block_allocator_top: drives requests and
// configuration writes, and gives the verdict from the scoreboard's failure count.
// Depends on sfba_pkg, the block itself and segregated_fixed_block_allocator_checker.
`timescale 1ns / 1ps

module segregated_fixed_block_allocator_top_test;
  import sfba_pkg::*;

  localparam int SMALL_BYTES  = 16;
  localparam int SMALL_COUNT  = 8;
  localparam int MEDIUM_BYTES = 32;
  localparam int MEDIUM_COUNT = 8;
  localparam int LARGE_BYTES  = 64;
  localparam int LARGE_COUNT  = 4;

  // Beats per configuration setting in the random part; six settings in all.
  localparam int BEATS_PER_SETTING = 235;
  // Idle margin after the last result has come back, to let the block settle.
  localparam int SETTLE_CYCLES     = 6;
  // Cycles with no beat on either channel before the run is declared hung.
  // At a 79 per cent idle rate a stretch this long is practically impossible.
  localparam int WATCHDOG_LIMIT    = 2000;

  logic        clk           = 1'b0;
  logic        rst           = 1'b1;
  logic        in_valid      = 1'b0;
  logic        opcode        = OP_ALLOC;
  logic [15:0] request_bytes = '0;
  logic [31:0] user_address  = '0;
  logic        out_stall     = 1'b0;
  logic        psel          = 1'b0;
  logic        penable       = 1'b0;
  logic        pwrite        = 1'b0;
  logic [2:0]  paddr         = '0;
  logic [31:0] pwdata        = '0;

  wire         in_stall;
  wire         out_valid;
  wire  [31:0] granted_address;
  wire  [1:0]  status;
  wire  [1:0]  pool_class;
  wire  [31:0] prdata;
  wire         pready;

  int mismatches;
  int outstanding;

  // Idle rates in per cent for the sender (gap) and the receiver (stall).
  int gap_pct   = 8;
  int stall_pct = 79;
  int idle_cycles = 0;

  // The configuration as last written, needed to aim frees at real blocks.
  logic [31:0] cur_base = '0;
  logic [3:0]  cur_hdr  = 4'd8;

  int pool_size[3]  = '{SMALL_BYTES, MEDIUM_BYTES, LARGE_BYTES};
  int pool_count[3] = '{SMALL_COUNT, MEDIUM_COUNT, LARGE_COUNT};
  int pool_start[3] = '{0, SMALL_BYTES * SMALL_COUNT,
                        SMALL_BYTES * SMALL_COUNT + MEDIUM_BYTES * MEDIUM_COUNT};

  segregated_fixed_block_allocator_top #(
    .SMALL_BYTES (SMALL_BYTES),
    .SMALL_COUNT (SMALL_COUNT),
    .MEDIUM_BYTES(MEDIUM_BYTES),
    .MEDIUM_COUNT(MEDIUM_COUNT),
    .LARGE_BYTES (LARGE_BYTES),
    .LARGE_COUNT (LARGE_COUNT)
  ) i_dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .opcode         (opcode),
    .request_bytes  (request_bytes),
    .user_address   (user_address),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .granted_address(granted_address),
    .status         (status),
    .pool_class     (pool_class),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  segregated_fixed_block_allocator_checker #(
    .SMALL_BYTES (SMALL_BYTES),
    .SMALL_COUNT (SMALL_COUNT),
    .MEDIUM_BYTES(MEDIUM_BYTES),
    .MEDIUM_COUNT(MEDIUM_COUNT),
    .LARGE_BYTES (LARGE_BYTES),
    .LARGE_COUNT (LARGE_COUNT)
  ) i_checker (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .opcode         (opcode),
    .request_bytes  (request_bytes),
    .user_address   (user_address),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .granted_address(granted_address),
    .status         (status),
    .pool_class     (pool_class),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .pready         (pready),
    .mismatches     (mismatches),
    .outstanding    (outstanding)
  );

  // 20 ns clock period.
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // The receiver stalls at random, at the rate of the current phase.
  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < stall_pct);
  end

  // The watchdog restarts whenever a beat moves on either channel, so a hang
  // anywhere in the block ends the run rather than leaving it spinning.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("segregated_fixed_block_allocator_top regression: fail");
      $finish;
    end
  end

  // Presents one request beat and returns at the edge that accepts it. Valid is
  // only lowered when a gap is taken, so back-to-back beats keep it high, and the
  // payload is held steady for as long as the block stalls.
  task automatic send_beat(input logic op, input logic [15:0] req, input logic [31:0] addr);
    if ($urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(0, 99) < gap_pct) @(posedge clk);
    end
    in_valid      <= 1'b1;
    opcode        <= op;
    request_bytes <= req;
    user_address  <= addr;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Waits until every predicted result has come back, then lets the pipeline
  // settle, so that configuration writes only ever land on an idle block.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Setup cycle, then access cycle; the register takes the data at the edge
  // where pready is seen high during the access cycle.
  task automatic write_reg(input logic idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic apply_setting(input logic [31:0] base, input logic [3:0] hdr);
    drain();
    write_reg(REG_REGION_BASE, base);
    write_reg(REG_HEADER_BYTES, {28'b0, hdr});
    cur_base = base;
    cur_hdr  = hdr;
  endtask

  // The address that an allocate of block i of pool c hands out.
  function automatic logic [31:0] block_user_address(int c, int i);
    return cur_base + pool_start[c] + i * pool_size[c] + cur_hdr;
  endfunction

  // Most beats are sensible allocate and free traffic, so the free lists are
  // emptied, refilled and reordered; a minority are near misses and noise.
  task automatic random_request();
    int          c;
    int          roll;
    int          room;
    int          sz;
    int          d;
    logic [31:0] a;
    roll = $urandom_range(0, 99);
    c    = $urandom_range(0, 2);
    room = pool_size[c] - cur_hdr;
    if (room < 0) room = 0;
    if (roll < 45) begin
      // Allocate sized for a chosen pool, with a bias towards its boundary.
      case ($urandom_range(0, 3))
        0:       sz = room;
        1:       sz = room + 1;
        2:       sz = 0;
        default: sz = $urandom_range(0, room);
      endcase
      send_beat(OP_ALLOC, 16'(sz), $urandom());
    end else if (roll < 88) begin
      // Free of a real block: a good free if it is in use, else a double free.
      a = block_user_address(c, $urandom_range(0, pool_count[c] - 1));
      send_beat(OP_FREE, 16'($urandom()), a);
    end else if (roll < 94) begin
      // Near miss: an address a little off a block start.
      a = block_user_address(c, $urandom_range(0, pool_count[c] - 1));
      d = $urandom_range(1, pool_size[c] - 1);
      if ($urandom_range(0, 1)) a = a + d;
      else a = a - d;
      send_beat(OP_FREE, 16'($urandom()), a);
    end else begin
      send_beat(logic'($urandom_range(0, 1)), 16'($urandom()), $urandom());
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part under the reset configuration: base zero, header of eight.
    // Each pool's boundary sizes, both sizes that fit nothing, and the large
    // pool drained until it reports empty.
    send_beat(OP_ALLOC, 16'd0, 32'hFFFF_FFFF);
    send_beat(OP_ALLOC, 16'd8, 32'hFFFF_FFFF);
    send_beat(OP_ALLOC, 16'd9, 32'hFFFF_FFFF);
    send_beat(OP_ALLOC, 16'd24, 32'hFFFF_FFFF);
    send_beat(OP_ALLOC, 16'd25, 32'hFFFF_FFFF);
    send_beat(OP_ALLOC, 16'd56, 32'hFFFF_FFFF);
    send_beat(OP_ALLOC, 16'd57, 32'hFFFF_FFFF);
    send_beat(OP_ALLOC, 16'hFFFF, 32'hFFFF_FFFF);
    repeat (3) send_beat(OP_ALLOC, 16'd56, 32'h0);
    // A good free followed by a double free of the same block.
    send_beat(OP_FREE, 16'hFFFF, block_user_address(2, 0));
    send_beat(OP_FREE, 16'hFFFF, block_user_address(2, 0));
    // Bad addresses: below the region, at the top of the address space,
    // misaligned inside a block, and just past the last large block.
    send_beat(OP_FREE, 16'hFFFF, 32'h0);
    send_beat(OP_FREE, 16'hFFFF, 32'hFFFF_FFFF);
    send_beat(OP_FREE, 16'hFFFF, block_user_address(0, 0) + 1);
    send_beat(OP_FREE, 16'hFFFF, block_user_address(2, LARGE_COUNT));
    // Freeing a small block and allocating again must hand the same one back.
    send_beat(OP_FREE, 16'h0, block_user_address(0, 0));
    send_beat(OP_ALLOC, 16'd1, 32'h0);

    // Random part over several settings, including both extremes of each
    // register and a base that makes block addresses wrap past the top.
    for (int s = 0; s < 6; s++) begin
      case (s)
        0:       apply_setting(32'h0, 4'd8);
        1:       apply_setting(32'hFFFF_FFF0, 4'd15);
        2:       apply_setting(32'h8000_0000, 4'd0);
        3:       apply_setting($urandom(), 4'($urandom_range(0, 15)));
        4:       apply_setting(32'hFFFF_FFFF, 4'd0);
        default: apply_setting($urandom() & 32'hFFFF_FFF0, 4'd8);
      endcase
      // Sender lightly idle with a busy receiver, then the reverse, then
      // flat out on both sides.
      if (s < 2) begin
        gap_pct   = 8;
        stall_pct = 79;
      end else if (s < 4) begin
        gap_pct   = 79;
        stall_pct = 8;
      end else begin
        gap_pct   = 0;
        stall_pct = 0;
      end
      repeat (BEATS_PER_SETTING) random_request();
    end

    drain();
    if (mismatches == 0 && outstanding == 0) begin
      $display("segregated_fixed_block_allocator_top regression: pass");
    end else begin
      $display("segregated_fixed_block_allocator_top regression: fail");
    end
    $finish;
  end

endmodule
